// File: hdl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  // Default number of heap slots
  localparam int unsigned CAPACITY_DEF = 128;

  // Key and result field widths
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 8;

  // Operation selector carried on the input tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

`default_nettype wire

// File: hdl/mhpq_store.sv
// Heap slot memory: one write port, one read port, registered read data.
// Depends on mhpq_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_store
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [CAPACITY];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/mhpq_ctrl.sv
// Heap sequencer: sift-up on insert, sift-down on delete, result register.
// Depends on mhpq_pkg; drives the ports of mhpq_store.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned SW = CW + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item in
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_kind_i,
  input  wire logic [VAL_W-1:0]   in_value_i,
  // result out
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [VAL_W-1:0]   out_removed_o,
  output logic      [STAT_W-1:0]  out_status_o,
  output logic      [COUNT_W-1:0] out_count_o,
  // memory
  output logic                    mem_we_o,
  output logic      [AW-1:0]      mem_waddr_o,
  output logic      [VAL_W-1:0]   mem_wdata_o,
  output logic      [AW-1:0]      mem_raddr_o,
  input  wire logic [VAL_W-1:0]   mem_rdata_i
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_UP_RD   = 11'b000_0000_0010,
    S_UP_CMP  = 11'b000_0000_0100,
    S_UP_FIN  = 11'b000_0000_1000,
    S_DN_TOP  = 11'b000_0001_0000,
    S_DN_LAST = 11'b000_0010_0000,
    S_DN_GOT  = 11'b000_0100_0000,
    S_DN_CHK  = 11'b000_1000_0000,
    S_DN_LEFT = 11'b001_0000_0000,
    S_DN_CMP  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [SW-1:0] SlotOne  = SW'(1);
  localparam logic [SW-1:0] SlotTwo  = SW'(2);

  state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SW-1:0]     i_q, i_d;         // sift-up or sift-down hole, or old last slot on delete
  logic [SW-1:0]     child_q, child_d;
  logic              two_q, two_d;     // both children present
  logic [VAL_W-1:0]  key_q, key_d;     // insert key or moving last entry
  logic [VAL_W-1:0]  left_q, left_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  status_e           res_st_q, res_st_d;
  logic              ov_q, ov_d;
  logic [VAL_W-1:0]  ov_val_q, ov_val_d;
  logic [STAT_W-1:0] ov_st_q, ov_st_d;
  logic [COUNT_W-1:0] ov_cnt_q, ov_cnt_d;

  logic [SW-1:0] rd_slot, wr_slot, rd_m1, wr_m1;
  logic [SW-1:0] cnt_ext, big_idx, half_i;
  logic [VAL_W-1:0] big_val;
  logic [CW+COUNT_W-1:0] cnt_wide;

  assign cnt_ext  = {1'b0, cnt_q};
  assign half_i   = i_q >> 1;
  assign cnt_wide = {{COUNT_W{1'b0}}, cnt_q};

  // Larger child, left wins a tie
  always_comb begin
    if (two_q && ($signed(mem_rdata_i) > $signed(left_q))) begin
      big_val = mem_rdata_i;
      big_idx = child_q + SlotOne;
    end else if (two_q) begin
      big_val = left_q;
      big_idx = child_q;
    end else begin
      big_val = mem_rdata_i;
      big_idx = child_q;
    end
  end

  // Slot number to memory address
  assign rd_m1       = rd_slot - SlotOne;
  assign wr_m1       = wr_slot - SlotOne;
  assign mem_raddr_o = rd_m1[AW-1:0];
  assign mem_waddr_o = wr_m1[AW-1:0];

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ov_q;
  assign out_removed_o = ov_val_q;
  assign out_status_o  = ov_st_q;
  assign out_count_o   = ov_cnt_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    child_d   = child_q;
    two_d     = two_q;
    key_d     = key_q;
    left_d    = left_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    ov_d      = ov_q;
    ov_val_d  = ov_val_q;
    ov_st_d   = ov_st_q;
    ov_cnt_d  = ov_cnt_q;
    rd_slot     = SlotOne;
    wr_slot     = SlotOne;
    mem_we_o    = 1'b0;
    mem_wdata_o = key_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d     = in_value_i;
          res_val_d = '0;
          res_st_d  = ST_OK;
          if (in_kind_i == KIND_INSERT) begin
            if (cnt_q >= CapCount) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              cnt_d = cnt_q + CW'(1);
              i_d   = cnt_ext + SlotOne;
              state_d = (cnt_q == '0) ? S_UP_FIN : S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              res_val_d = '1;
              res_st_d  = ST_EMPTY;
              state_d   = S_DONE;
            end else begin
              i_d     = cnt_ext;
              cnt_d   = cnt_q - CW'(1);
              state_d = S_DN_TOP;
            end
          end
        end
      end
      S_UP_RD: begin
        rd_slot = half_i;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        // rdata holds the parent of the hole
        wr_slot  = i_q;
        mem_we_o = 1'b1;
        if ($signed(key_q) > $signed(mem_rdata_i)) begin
          mem_wdata_o = mem_rdata_i;
          i_d         = half_i;
          rd_slot     = half_i >> 1;
          if (half_i == SlotOne) begin
            state_d = S_UP_FIN;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP_FIN: begin
        wr_slot  = i_q;
        mem_we_o = 1'b1;
        state_d  = S_DONE;
      end
      S_DN_TOP: begin
        rd_slot = SlotOne;
        state_d = S_DN_LAST;
      end
      S_DN_LAST: begin
        res_val_d = mem_rdata_i;
        rd_slot   = i_q;
        state_d   = S_DN_GOT;
      end
      S_DN_GOT: begin
        key_d   = mem_rdata_i;
        i_d     = SlotOne;
        child_d = SlotTwo;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        // i_q is the hole, child_q its left child
        if (child_q > cnt_ext) begin
          wr_slot  = i_q;
          mem_we_o = 1'b1;
          state_d  = S_DONE;
        end else begin
          rd_slot = child_q;
          two_d   = (child_q < cnt_ext);
          state_d = (child_q < cnt_ext) ? S_DN_LEFT : S_DN_CMP;
        end
      end
      S_DN_LEFT: begin
        left_d  = mem_rdata_i;
        rd_slot = child_q + SlotOne;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        wr_slot  = i_q;
        mem_we_o = 1'b1;
        if ($signed(key_q) >= $signed(big_val)) begin
          state_d = S_DONE;
        end else begin
          mem_wdata_o = big_val;
          i_d         = big_idx;
          child_d     = {big_idx[SW-2:0], 1'b0};
          state_d     = S_DN_CHK;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          ov_val_d = res_val_q;
          ov_st_d  = res_st_q;
          ov_cnt_d = cnt_wide[COUNT_W-1:0];
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    child_q   <= child_d;
    two_q     <= two_d;
    key_q     <= key_d;
    left_q    <= left_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    ov_val_q  <= ov_val_d;
    ov_st_q   <= ov_st_d;
    ov_cnt_q  <= ov_cnt_d;
  end

endmodule

`default_nettype wire

// File: hdl/max_heap_priority_queue_core.sv
// Top level of the binary max-heap priority queue: stream ports, sequencer, slot memory.
// Depends on mhpq_pkg, mhpq_store and mhpq_ctrl.
//
//   channel  | dir | tdata (low bit first)                       | tuser
//   s_axis   | in  | value[31:0]                                 | kind
//   m_axis   | out | removed_value[31:0] status[33:32]           | -
//            |     | entry_count[41:34], zero pad to 48          |
//
// Insert sifts up from the new last slot, one parent compare per heap level, then writes the key.
// Delete reads the root and the old last entry, then sifts down with up to two child reads and
// a compare per level through the single memory read port.
// Reset empties the heap at once; memory contents are never cleared.
// A finished result is held in the output register; the next word is taken
// while it waits, and completion stalls until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_core
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // value[31:0]
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata   // removed_value, status, entry_count, pad
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VAL_W-1:0]   mem_rdata;
  logic [VAL_W-1:0]   res_value;
  logic [STAT_W-1:0]  res_status;
  logic [COUNT_W-1:0] res_count;

  mhpq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_removed_o(res_value),
    .out_status_o (res_status),
    .out_count_o  (res_count),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  mhpq_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output word packing
  assign m_axis_tdata = {6'b0, res_count, res_status, res_value};

endmodule

`default_nettype wire

// File: sim/max_heap_priority_queue_core_test.sv
// Self-checking testbench for max_heap_priority_queue_core: a behavioral heap
// predicts every result word, and a monitor checks words as they leave the block.
// Depends on mhpq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_test
  import mhpq_pkg::*;
();

  localparam int unsigned HEAP_SLOTS  = CAPACITY_DEF;
  localparam int          QUIET_LIMIT = 3000;   // cycles with no handshake on either side
  localparam int          DRAIN_WAIT  = 60;     // above the longest delete latency

  // One predicted output word
  typedef struct packed {
    logic signed [VAL_W-1:0] removed;
    status_e                 status;
    logic [COUNT_W-1:0]      count;
  } heap_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // value[31:0]
  logic        s_axis_tuser  = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // removed_value[31:0], status[33:32], entry_count[41:34]

  // Behavioral heap, slot 1 is the root
  logic signed [VAL_W-1:0] heap_model [1:HEAP_SLOTS];
  int unsigned             heap_count = 0;
  heap_result_t            expected_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;

  max_heap_priority_queue_core #(
    .CAPACITY(HEAP_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Apply one operation to the behavioral heap and return the word it should produce
  function automatic heap_result_t apply_heap_op(logic kind, logic signed [VAL_W-1:0] key);
    heap_result_t            res;
    int unsigned             idx;
    int unsigned             parent;
    int unsigned             child;
    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] last;
    res.removed = '0;
    res.status  = ST_OK;
    if (kind == KIND_INSERT) begin
      if (heap_count >= HEAP_SLOTS) begin
        res.status = ST_FULL;
      end else begin
        // sift up from the new last slot
        heap_count++;
        idx = heap_count;
        while (idx != 1 && key > heap_model[idx / 2]) begin
          heap_model[idx] = heap_model[idx / 2];
          idx = idx / 2;
        end
        heap_model[idx] = key;
      end
    end else if (heap_count == 0) begin
      res.removed = -1;
      res.status  = ST_EMPTY;
    end else begin
      // sift the old last entry down, larger child wins, left on a tie
      top  = heap_model[1];
      last = heap_model[heap_count];
      heap_count--;
      parent = 1;
      child  = 2;
      while (child <= heap_count) begin
        if (child < heap_count && heap_model[child] < heap_model[child + 1]) child++;
        if (last >= heap_model[child]) break;
        heap_model[parent] = heap_model[child];
        parent = child;
        child  = child * 2;
      end
      heap_model[parent] = last;
      res.removed = top;
    end
    res.count = heap_count[COUNT_W-1:0];
    return res;
  endfunction

  // Key mix: full range, a narrow band for ties, and the extremes
  function automatic logic signed [VAL_W-1:0] rand_key();
    logic signed [VAL_W-1:0] key;
    case ($urandom_range(3))
      0: key = $urandom_range(8) - 4;
      1: begin
        case ($urandom_range(3))
          0: key = 32'h8000_0000;
          1: key = 32'h7FFF_FFFF;
          2: key = 32'hFFFF_FFFF;
          default: key = '0;
        endcase
      end
      default: key = $urandom;
    endcase
    return key;
  endfunction

  // Offer one word until it is taken, then record its predicted result
  task automatic send_word(input logic kind, input logic signed [VAL_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(apply_heap_op(kind, key));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Output checker, receiver ready and handshake activity for the watchdog
  always @(posedge clk_i) begin
    heap_result_t exp_r;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result word %h with no operation pending", m_axis_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.removed || m_axis_tdata[33:32] !== exp_r.status ||
            m_axis_tdata[41:34] !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected removed=%0d status=%0d count=%0d, got %0d %0d %0d",
                     exp_r.removed, exp_r.status, exp_r.count,
                     $signed(m_axis_tdata[31:0]), m_axis_tdata[33:32], m_axis_tdata[41:34]);
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (hold_off_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Empty delete, extreme keys, ties, then empty again
  task automatic test_empty_and_extremes();
    int n;
    send_word(KIND_DELETE, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'h8000_0000);
    for (n = 0; n < 10; n++) send_word(KIND_DELETE, $urandom);
    send_word(KIND_DELETE, 32'h0000_0000);
  endtask

  // Fill to capacity, try two more inserts, then empty it out
  task automatic test_fill_and_drain();
    while (heap_count < HEAP_SLOTS) send_word(KIND_INSERT, rand_key());
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'h8000_0000);
    while (heap_count > 0) send_word(KIND_DELETE, $urandom);
    send_word(KIND_DELETE, $urandom);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stop_sending();
    @(negedge clk_i);
    hold_off_left = 300;
    @(posedge clk_i);
    for (n = 0; n < 24; n++)
      send_word(($urandom_range(2) == 0) ? KIND_DELETE : KIND_INSERT, rand_key());
    stop_sending();
    wait_drained();
  endtask

  // Random mix with a delete bias that steers the fill level
  task automatic run_random(input int items, input int idle_pct, input int stall_pct,
                            input int delete_pct);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < items; n++)
      send_word(($urandom_range(99) < delete_pct) ? KIND_DELETE : KIND_INSERT, rand_key());
  endtask

  task automatic test_random_mix();
    run_random(180, 0, 0, 35);
    run_random(180, 78, 0, 50);
    run_random(180, 0, 78, 65);
    run_random(180, 19, 19, 45);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    stop_sending();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
